FILE: hw/rtl/track_volume_pan_pitch_assert.svh
// assertion macros for the track mixer block
`ifndef TRACK_VOLUME_PAN_PITCH_ASSERT_SVH
`define TRACK_VOLUME_PAN_PITCH_ASSERT_SVH

// checked while out of reset
`define TVPP_ASSERT(lbl, clock, reset, prop) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("%m: assertion failed");

// checked during reset too
`define TVPP_ASSERT_NR(lbl, clock, prop) \
  lbl: assert property (@(posedge clock) prop) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/tvpp_pkg.sv
`default_nettype none

package tvpp_pkg;

  localparam logic [1:0] MOD_PITCH  = 2'd0;
  localparam logic [1:0] MOD_VOLUME = 2'd1;
  localparam logic [1:0] MOD_PAN    = 2'd2;
  localparam logic [1:0] MOD_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]        update_mask;
    logic [6:0]        track_volume;
    logic [7:0]        fade_volume;
    logic signed [7:0] track_pan;
    logic signed [7:0] pan_offset;
    logic [1:0]        mod_type;
    logic signed [7:0] mod_depth;
    logic signed [7:0] bend_amount;
    logic [7:0]        bend_range;
    logic signed [7:0] fine_tune;
    logic signed [7:0] key_shift;
    logic [7:0]        pitch_offset;
  } in_t;

  typedef struct packed {
    logic       volume_valid;
    logic [7:0] right_volume;
    logic [7:0] left_volume;
    logic       pitch_valid;
    logic [7:0] note_key;
    logic [7:0] pitch_fraction;
  } out_t;

  // per-stage load enables
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tvpp_vol_pipe.sv
`default_nettype none

module tvpp_vol_pipe (
  input  wire logic          clk,
  input  wire tvpp_pkg::ctl_t ctl,
  input  wire tvpp_pkg::in_t  in_data,
  output logic               volume_valid,
  output logic [7:0]         right_volume,
  output logic [7:0]         left_volume
);

  // stage 1: fade product, pan sum and clamp
  logic [14:0]        fade_prod;
  logic signed [10:0] pan_sum;
  logic [7:0]         pan_clamped;

  logic [9:0]  s1_xf;
  logic [7:0]  s1_mscale;
  logic        s1_modvol;
  logic [7:0]  s1_pan;
  logic        s1_en;

  assign fade_prod = {8'b0, in_data.track_volume} * {7'b0, in_data.fade_volume};

  always_comb begin
    pan_sum = {{2{in_data.track_pan[7]}}, in_data.track_pan, 1'b0}
            + {{3{in_data.pan_offset[7]}}, in_data.pan_offset};
    if (in_data.mod_type == tvpp_pkg::MOD_PAN) begin
      pan_sum = pan_sum + {{3{in_data.mod_depth[7]}}, in_data.mod_depth};
    end
    // out of range when the upper bits are not a plain sign extension
    if (pan_sum[10:7] == 4'b0000 || pan_sum[10:7] == 4'b1111) begin
      pan_clamped = pan_sum[7:0];
    end else if (pan_sum[10]) begin
      pan_clamped = 8'h80;
    end else begin
      pan_clamped = 8'h7F;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      s1_xf     <= fade_prod[14:5];
      // mod_depth + 128 as an unsigned byte
      s1_mscale <= {~in_data.mod_depth[7], in_data.mod_depth[6:0]};
      s1_modvol <= (in_data.mod_type == tvpp_pkg::MOD_VOLUME);
      s1_pan    <= pan_clamped;
      s1_en     <= in_data.update_mask[0];
    end
  end

  // stage 2: volume modulation
  logic [17:0] mod_prod;
  logic [10:0] vol_x;

  logic [10:0] s2_x;
  logic [7:0]  s2_pan;
  logic        s2_en;

  assign mod_prod = {8'b0, s1_xf} * {10'b0, s1_mscale};
  assign vol_x    = s1_modvol ? mod_prod[17:7] : {1'b0, s1_xf};

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      s2_x   <= vol_x;
      s2_pan <= s1_pan;
      s2_en  <= s1_en;
    end
  end

  // stage 3: split into right and left
  logic [7:0]  right_pan;
  logic [7:0]  left_pan;
  logic [18:0] right_prod;
  logic [18:0] left_prod;

  // pan + 128 and 127 - pan, both as unsigned bytes
  assign right_pan  = {~s2_pan[7], s2_pan[6:0]};
  assign left_pan   = {s2_pan[7], ~s2_pan[6:0]};
  assign right_prod = {11'b0, right_pan} * {8'b0, s2_x};
  assign left_prod  = {11'b0, left_pan} * {8'b0, s2_x};

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      volume_valid <= s2_en;
      right_volume <= s2_en ? right_prod[15:8] : 8'd0;
      left_volume  <= s2_en ? left_prod[15:8] : 8'd0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tvpp_pitch_pipe.sv
`default_nettype none

module tvpp_pitch_pipe (
  input  wire logic          clk,
  input  wire tvpp_pkg::ctl_t ctl,
  input  wire tvpp_pkg::in_t  in_data,
  input  wire logic [7:0]    player_transpose,
  output logic               pitch_valid,
  output logic [7:0]         note_key,
  output logic [7:0]         pitch_fraction
);

  // stage 1: bend product, semitone sum, modulation term
  logic signed [16:0] bend_prod;

  logic [15:0] s1_bend;
  logic [7:0]  s1_tune;
  logic [7:0]  s1_key;
  logic [7:0]  s1_pofs;
  logic [15:0] s1_mod;
  logic        s1_en;

  assign bend_prod = $signed({{9{in_data.bend_amount[7]}}, in_data.bend_amount})
                   * $signed({9'b0, in_data.bend_range});

  always_ff @(posedge clk) begin
    if (ctl.adv1) begin
      s1_bend <= bend_prod[15:0];
      s1_tune <= in_data.fine_tune;
      // only the low byte of the semitone sum reaches the 16-bit result
      s1_key  <= in_data.key_shift + player_transpose;
      s1_pofs <= in_data.pitch_offset;
      s1_mod  <= (in_data.mod_type == tvpp_pkg::MOD_PITCH)
               ? {{4{in_data.mod_depth[7]}}, in_data.mod_depth, 4'b0000} : 16'd0;
      s1_en   <= in_data.update_mask[1];
    end
  end

  // stage 2: two partial sums, all modulo 2^16
  logic [15:0] fine_sum;
  logic [15:0] part_a;
  logic [15:0] part_b;

  logic [15:0] s2_a;
  logic [15:0] s2_b;
  logic        s2_en;

  assign fine_sum = {{8{s1_tune[7]}}, s1_tune} + s1_bend;
  assign part_a   = {fine_sum[13:0], 2'b00} + {8'b0, s1_pofs};
  assign part_b   = {s1_key, 8'b0} + s1_mod;

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      s2_a  <= part_a;
      s2_b  <= part_b;
      s2_en <= s1_en;
    end
  end

  // stage 3: final sum
  logic [15:0] pitch_sum;

  assign pitch_sum = s2_a + s2_b;

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      pitch_valid    <= s2_en;
      note_key       <= s2_en ? pitch_sum[15:8] : 8'd0;
      pitch_fraction <= s2_en ? pitch_sum[7:0] : 8'd0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/track_volume_pan_pitch.sv
// Track mixer settings: volume, pan split and pitch of one sequencer track.
// Input channel in_valid/in_ready/in_data carries one track's settings per
// beat; output channel out_valid/out_ready/out_data returns one result per
// input beat, in order. Fields not requested by update_mask read as zero.
// Config channel cfg_valid/cfg_ready/cfg_data writes player_transpose; it is
// always ready and must be written only while the block is idle.
// An accepted beat moves through the stage 1 and 2 registers into out_data,
// the stage 3 register. Throughput: one beat per cycle unless out_ready
// stalls; three register stages hold multiplies up to 8x11 and 16-bit adds.
// Reset (rst, synchronous) empties the pipeline and clears player_transpose.
// When the receiver stalls, the result is held on out_data and the stages
// behind it keep filling; in_ready drops only once all three stages are full.
`default_nettype none

module track_volume_pan_pitch (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tvpp_pkg::in_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tvpp_pkg::out_t  out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic           v1;
  logic           v2;
  logic           v3;
  logic [7:0]     player_transpose;
  tvpp_pkg::ctl_t ctl;

  // a stage loads when it is empty or its contents move on
  assign ctl.adv3 = !v3 || out_ready;
  assign ctl.adv2 = !v2 || ctl.adv3;
  assign ctl.adv1 = !v1 || ctl.adv2;

  assign in_ready  = ctl.adv1;
  assign out_valid = v3;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ctl.adv1) v1 <= in_valid;
      if (ctl.adv2) v2 <= v1;
      if (ctl.adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      player_transpose <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      player_transpose <= cfg_data;
    end
  end

  tvpp_vol_pipe u_vol (
    .clk          (clk),
    .ctl          (ctl),
    .in_data      (in_data),
    .volume_valid (out_data.volume_valid),
    .right_volume (out_data.right_volume),
    .left_volume  (out_data.left_volume)
  );

  tvpp_pitch_pipe u_pitch (
    .clk              (clk),
    .ctl              (ctl),
    .in_data          (in_data),
    .player_transpose (player_transpose),
    .pitch_valid      (out_data.pitch_valid),
    .note_key         (out_data.note_key),
    .pitch_fraction   (out_data.pitch_fraction)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tvpp_checker.sv
`default_nettype none

`include "track_volume_pan_pitch_assert.svh"

module tvpp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire tvpp_pkg::in_t  in_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire tvpp_pkg::out_t out_data,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [7:0] cfg_data
);

  logic unused_ok;

  assign unused_ok = in_valid ^ (^in_data) ^ cfg_valid ^ cfg_ready ^ (^cfg_data);

  // stalled result holds
  `TVPP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // the pipeline only backs up when the output beat is stuck
  `TVPP_ASSERT(a_ready_free, clk, rst, !out_valid || out_ready |-> in_ready)
  // fields not recomputed read as zero
  `TVPP_ASSERT(a_vol_zero, clk, rst, out_valid && !out_data.volume_valid |-> out_data.right_volume == 8'd0 && out_data.left_volume == 8'd0)
  `TVPP_ASSERT(a_pitch_zero, clk, rst, out_valid && !out_data.pitch_valid |-> out_data.note_key == 8'd0 && out_data.pitch_fraction == 8'd0)
  // reset empties the pipeline
  `TVPP_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind track_volume_pan_pitch tvpp_checker u_tvpp_checker (.*);

`default_nettype wire
